[rtl/mfde_pkg.sv]
`timescale 1ns / 1ps
package mfde_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int CW = 13;

	localparam logic [2:0] K_CLEAR   = 3'd0;
	localparam logic [2:0] K_PIXEL   = 3'd1;
	localparam logic [2:0] K_FILL    = 3'd2;
	localparam logic [2:0] K_OUTLINE = 3'd3;
	localparam logic [2:0] K_CIRCLE  = 3'd4;
	localparam logic [2:0] K_LINE    = 3'd5;
	localparam logic [2:0] K_READ    = 3'd6;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [1:0] OP_PIX_WR  = 2'd0;
	localparam logic [1:0] OP_PIX_RD  = 2'd1;
	localparam logic [1:0] OP_BYTE_WR = 2'd2;

	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic [7:0] BYTE_BLACK = 8'h00;
	localparam logic [7:0] MASK_MSB   = 8'h80;
	localparam logic [2:0] BIT_SEL    = 3'h7;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           op;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 color;
		logic [17:0]          baddr;
	} mfde_req_t;

	typedef struct packed {
		logic done;
		logic bit_val;
	} mfde_rsp_t;

endpackage

[rtl/mfde_pixel_rmw.sv]
`timescale 1ns / 1ps
module mfde_pixel_rmw #(
	parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [9:0]          eff_w,
	input  logic [9:0]          eff_h,
	input  logic [7:0]          row_bytes,
	input  mfde_pkg::mfde_req_t req,
	output mfde_pkg::mfde_rsp_t rsp
);
	import mfde_pkg::*;

	localparam int DEPTH = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] PU_IDLE = 2'd0;
	localparam logic [1:0] PU_RD   = 2'd1;
	localparam logic [1:0] PU_WR   = 2'd2;

	logic [7:0]    mem [DEPTH];
	logic [1:0]    state_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    mask_q;
	logic [7:0]    rdata_q;
	logic          color_q;
	logic          rd_q;
	logic          done_q;
	logic          bit_q;

	logic          on_canvas;
	logic [17:0]   addr_full;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	assign on_canvas = (req.x >= 0) && (req.y >= 0)
		&& (req.x < $signed({3'b0, eff_w})) && (req.y < $signed({3'b0, eff_h}));
	assign addr_full = 18'(req.y[9:0] * row_bytes) + 18'(req.x[9:3]);

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = color_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
		if (state_q == PU_IDLE && req.valid && req.op == OP_BYTE_WR) begin
			we    = 1'b1;
			waddr = req.baddr[AW-1:0];
			wdata = req.color ? BYTE_WHITE : BYTE_BLACK;
		end else if (state_q == PU_WR && !rd_q) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (state_q == PU_RD) begin
			rdata_q <= mem[addr_q];
		end
		if (state_q == PU_IDLE && req.valid) begin
			addr_q  <= addr_full[AW-1:0];
			mask_q  <= MASK_MSB >> (req.x[2:0] & BIT_SEL);
			color_q <= req.color;
			rd_q    <= (req.op == OP_PIX_RD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PU_IDLE;
			done_q  <= 1'b0;
			bit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				PU_IDLE: begin
					if (req.valid) begin
						if (req.op == OP_BYTE_WR || !on_canvas) begin
							done_q <= 1'b1;
							bit_q  <= 1'b1;
						end else begin
							state_q <= PU_RD;
						end
					end
				end
				PU_RD: state_q <= PU_WR;
				PU_WR: begin
					done_q  <= 1'b1;
					bit_q   <= |(rdata_q & mask_q);
					state_q <= PU_IDLE;
				end
				default: state_q <= PU_IDLE;
			endcase
		end
	end

	assign rsp.done    = done_q;
	assign rsp.bit_val = bit_q;

endmodule

[rtl/mono_framebuffer_draw_engine_core.sv]
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | kind x_a y_a x_b y_b size_w size_h radius white brush
// out     | output    | out_valid / out_ready| pixel_white
// cfg     | input     | cfg_we               | cfg_index cfg_data
// Each drawn pixel is a read-modify-write of one byte in the single-port frame store,
// one pixel at a time; a circle test that misses issues no store access.
// Clear writes each byte of the canvas in turn. Pixel and read each access at most one byte.
// in_ready is high only while idle; a finished result waits for out_ready.
// Reset clears control state only; the frame store is not initialized.
module mono_framebuffer_draw_engine_core #(
	parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [10:0] x_a,
	input  logic signed [10:0] y_a,
	input  logic signed [10:0] x_b,
	input  logic signed [10:0] y_b,
	input  logic signed [10:0] size_w,
	input  logic signed [10:0] size_h,
	input  logic [7:0]         radius,
	input  logic               white,
	input  logic [3:0]         brush,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               pixel_white
);
	import mfde_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CLR       = 4'd1;
	localparam logic [3:0] S_PIX       = 4'd2;
	localparam logic [3:0] S_BOX_INIT  = 4'd3;
	localparam logic [3:0] S_BOX_PIX   = 4'd4;
	localparam logic [3:0] S_OUTL      = 4'd5;
	localparam logic [3:0] S_LINE_BOX  = 4'd6;
	localparam logic [3:0] S_LINE_STEP = 4'd7;
	localparam logic [3:0] S_CIR_PIX   = 4'd8;
	localparam logic [3:0] S_DONE      = 4'd9;

	logic [8:0]  cfg_w_q, cfg_h_q;
	logic [9:0]  eff_w, eff_h;
	logic [7:0]  row_bytes;
	logic [10:0] rb_sum;
	logic        engine_on;

	logic [3:0]  state_q;
	logic        pend_q;
	logic        res_q;
	logic        out_valid_q, pix_q;

	logic [2:0]         kind_q;
	logic signed [10:0] xa_q, ya_q, xb_q, yb_q, sw_q, sh_q;
	logic [7:0]         rad_q;
	logic               white_q;

	logic [17:0] clr_cnt_q, clr_total_q;

	logic signed [CW-1:0] bx_q, by_q, bw_q, bh_q;
	logic signed [CW-1:0] bx0_q, bx1_q, by1_q, bc_q, br_q;
	logic [2:0]           side_q;

	logic signed [13:0] ldx_q, ldy_q, err_q;
	logic               sx_q, sy_q;
	logic signed [10:0] lx_q, ly_q;
	logic [3:0]         t_q;

	logic signed [9:0] cdx_q, cdy_q;
	logic [17:0]       dx2_q, dy2_q, r2_q;

	mfde_req_t req;
	mfde_rsp_t rsp;

	logic signed [CW-1:0] ew_s, eh_s;
	logic signed [CW-1:0] bxe, bye, bx0, by0, bx1, by1;
	logic [3:0]           box_ret;
	logic signed [14:0]   e2;
	logic                 st_x, st_y;
	logic signed [13:0]   err_n;
	logic signed [CW-1:0] cpx, cpy;
	logic [18:0]          csum;
	logic                 chit, cdx_end, cdy_end;
	logic signed [11:0]   ldxs, ldys;

	assign eff_w = ({2'b0, cfg_w_q} > 11'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : {1'b0, cfg_w_q};
	assign eff_h = ({2'b0, cfg_h_q} > 11'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : {1'b0, cfg_h_q};
	assign rb_sum    = {1'b0, eff_w} + 11'd7;
	assign row_bytes = rb_sum[10:3];
	assign engine_on = (eff_w != 10'd0) && (eff_h != 10'd0);
	assign ew_s = $signed({3'b0, eff_w});
	assign eh_s = $signed({3'b0, eff_h});

	assign bxe = bx_q + bw_q;
	assign bye = by_q + bh_q;
	assign bx0 = (bx_q < 0) ? '0 : bx_q;
	assign by0 = (by_q < 0) ? '0 : by_q;
	assign bx1 = (bxe > ew_s) ? ew_s : bxe;
	assign by1 = (bye > eh_s) ? eh_s : bye;

	always_comb begin
		unique case (kind_q)
			K_OUTLINE: box_ret = S_OUTL;
			K_LINE:    box_ret = S_LINE_STEP;
			default:   box_ret = S_DONE;
		endcase
	end

	assign e2    = 15'(err_q) <<< 1;
	assign st_x  = e2 >= 15'(ldy_q);
	assign st_y  = e2 <= 15'(ldx_q);
	assign err_n = err_q + (st_x ? ldy_q : 14'sd0) + (st_y ? ldx_q : 14'sd0);

	assign ldxs = 12'(x_b) - 12'(x_a);
	assign ldys = 12'(y_b) - 12'(y_a);

	assign cpx     = CW'(xa_q) + CW'(cdx_q);
	assign cpy     = CW'(ya_q) + CW'(cdy_q);
	assign csum    = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign chit    = (cpx >= 0) && (cpx < ew_s) && (cpy >= 0) && (cpy < eh_s)
		&& (csum <= {1'b0, r2_q});
	assign cdx_end = cdx_q == $signed({2'b0, rad_q});
	assign cdy_end = cdy_q == $signed({2'b0, rad_q});

	always_comb begin
		req.valid = 1'b0;
		req.op    = OP_PIX_WR;
		req.x     = bc_q;
		req.y     = br_q;
		req.color = white_q;
		req.baddr = clr_cnt_q;
		unique case (state_q)
			S_CLR: begin
				req.valid = !pend_q;
				req.op    = OP_BYTE_WR;
			end
			S_PIX: begin
				req.valid = !pend_q;
				req.op    = (kind_q == K_READ) ? OP_PIX_RD : OP_PIX_WR;
				req.x     = CW'(xa_q);
				req.y     = CW'(ya_q);
			end
			S_BOX_PIX: req.valid = !pend_q;
			S_CIR_PIX: begin
				req.valid = chit && !pend_q;
				req.x     = cpx;
				req.y     = cpy;
			end
			default: req.valid = 1'b0;
		endcase
	end

	mfde_pixel_rmw #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_rmw (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.row_bytes(row_bytes),
		.req      (req),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= '0;
			cfg_h_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_w_q <= cfg_data;
				REG_HEIGHT: cfg_h_q <= cfg_data;
				default:    cfg_w_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			xa_q    <= x_a;
			ya_q    <= y_a;
			xb_q    <= x_b;
			yb_q    <= y_b;
			sw_q    <= size_w;
			sh_q    <= size_h;
			rad_q   <= radius;
			white_q <= white;
			t_q     <= (brush == 4'd0) ? 4'd1 : brush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pix_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (req.valid) begin
				pend_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q <= 1'b0;
						unique case (kind)
							K_CLEAR: begin
								clr_cnt_q   <= '0;
								clr_total_q <= 18'(row_bytes * eff_h);
								state_q     <= engine_on ? S_CLR : S_DONE;
							end
							K_PIXEL, K_READ: state_q <= S_PIX;
							K_FILL: begin
								bx_q    <= CW'(x_a);
								by_q    <= CW'(y_a);
								bw_q    <= CW'(size_w);
								bh_q    <= CW'(size_h);
								state_q <= S_BOX_INIT;
							end
							K_OUTLINE: begin
								side_q  <= '0;
								state_q <= (engine_on && size_w > 0 && size_h > 0) ?
									S_OUTL : S_DONE;
							end
							K_CIRCLE: begin
								cdx_q   <= -$signed({2'b0, radius});
								cdy_q   <= -$signed({2'b0, radius});
								r2_q    <= 18'(radius * radius);
								dx2_q   <= 18'(radius * radius);
								dy2_q   <= 18'(radius * radius);
								state_q <= (engine_on && radius != 8'd0) ? S_CIR_PIX : S_DONE;
							end
							K_LINE: begin
								ldx_q   <= 14'((ldxs < 0) ? -ldxs : ldxs);
								ldy_q   <= -14'((ldys < 0) ? -ldys : ldys);
								err_q   <= 14'((ldxs < 0) ? -ldxs : ldxs)
									- 14'((ldys < 0) ? -ldys : ldys);
								sx_q    <= x_a < x_b;
								sy_q    <= y_a < y_b;
								lx_q    <= x_a;
								ly_q    <= y_a;
								state_q <= engine_on ? S_LINE_BOX : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLR: begin
					if (rsp.done) begin
						pend_q    <= 1'b0;
						clr_cnt_q <= clr_cnt_q + 18'd1;
						if (clr_cnt_q + 18'd1 == clr_total_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_PIX: begin
					if (rsp.done) begin
						pend_q  <= 1'b0;
						res_q   <= (kind_q == K_READ) ? rsp.bit_val : 1'b0;
						state_q <= S_DONE;
					end
				end
				S_BOX_INIT: begin
					bx0_q <= bx0;
					bx1_q <= bx1;
					by1_q <= by1;
					bc_q  <= bx0;
					br_q  <= by0;
					if (!engine_on || bw_q <= 0 || bh_q <= 0 || bx0 >= bx1 || by0 >= by1) begin
						state_q <= box_ret;
					end else begin
						state_q <= S_BOX_PIX;
					end
				end
				S_BOX_PIX: begin
					if (rsp.done) begin
						pend_q <= 1'b0;
						if (bc_q + CW'(1) == bx1_q) begin
							bc_q <= bx0_q;
							br_q <= br_q + CW'(1);
							if (br_q + CW'(1) == by1_q) begin
								state_q <= box_ret;
							end
						end else begin
							bc_q <= bc_q + CW'(1);
						end
					end
				end
				S_OUTL: begin
					side_q <= side_q + 3'd1;
					bx_q   <= CW'(xa_q);
					by_q   <= CW'(ya_q);
					bw_q   <= CW'(sw_q);
					bh_q   <= CW'(sh_q);
					state_q <= S_BOX_INIT;
					unique case (side_q)
						3'd0: bh_q <= CW'(1);
						3'd1: begin
							by_q <= CW'(ya_q) + CW'(sh_q) - CW'(1);
							bh_q <= CW'(1);
						end
						3'd2: bw_q <= CW'(1);
						3'd3: begin
							bx_q <= CW'(xa_q) + CW'(sw_q) - CW'(1);
							bw_q <= CW'(1);
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LINE_BOX: begin
					bx_q    <= CW'(lx_q) - CW'(t_q[3:1]);
					by_q    <= CW'(ly_q) - CW'(t_q[3:1]);
					bw_q    <= CW'(t_q);
					bh_q    <= CW'(t_q);
					state_q <= S_BOX_INIT;
				end
				S_LINE_STEP: begin
					if (lx_q == xb_q && ly_q == yb_q) begin
						state_q <= S_DONE;
					end else begin
						err_q <= err_n;
						if (st_x) begin
							lx_q <= sx_q ? lx_q + 11'sd1 : lx_q - 11'sd1;
						end
						if (st_y) begin
							ly_q <= sy_q ? ly_q + 11'sd1 : ly_q - 11'sd1;
						end
						state_q <= S_LINE_BOX;
					end
				end
				S_CIR_PIX: begin
					if (!chit || (pend_q && rsp.done)) begin
						pend_q <= 1'b0;
						if (cdx_end) begin
							cdx_q <= -$signed({2'b0, rad_q});
							dx2_q <= r2_q;
							cdy_q <= cdy_q + 10'sd1;
							dy2_q <= dy2_q + 18'($signed({cdy_q, 1'b1}));
							if (cdy_end) begin
								state_q <= S_DONE;
							end
						end else begin
							cdx_q <= cdx_q + 10'sd1;
							dx2_q <= dx2_q + 18'($signed({cdx_q, 1'b1}));
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						pix_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign pixel_white = pix_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import mfde_pkg::*;

	localparam int MAX_W = MAX_WIDTH_DEF;
	localparam int MAX_H = MAX_HEIGHT_DEF;
	localparam int STORE_SZ = ((MAX_W + 7) / 8) * MAX_H;
	localparam logic [2:0] K_UNUSED = 3'd7;

	typedef struct {
		logic [2:0]         kind;
		logic signed [10:0] xa, ya, xb, yb, sw, sh;
		logic [7:0]         rad;
		logic               wht;
		logic [3:0]         br;
	} draw_cmd_t;

	typedef struct {
		bit        is_cfg;
		logic      cfg_idx;
		logic [8:0] cfg_val;
		draw_cmd_t c;
		bit        has_exp;
		bit        exp_px;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [8:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] kind = 0;
	logic signed [10:0] x_a = 0, y_a = 0, x_b = 0, y_b = 0, size_w = 0, size_h = 0;
	logic [7:0] radius = 0;
	logic white = 0;
	logic [3:0] brush = 0;
	logic out_valid;
	logic out_ready = 0;
	logic pixel_white;

	mono_framebuffer_draw_engine_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b),
		.size_w(size_w), .size_h(size_h), .radius(radius), .white(white), .brush(brush),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_white(pixel_white)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#200000000;
		$display("Some tests failed");
		$finish;
	end

	// mirror of the engine state
	logic [7:0] mirror_store [STORE_SZ];
	int unsigned canvas_w, canvas_h;
	bit pixel_q [$];

	int errors = 0;
	int mismatches = 0;
	int cmds_sent = 0;
	int reads_checked = 0;
	int settings_done = 0;
	bit no_idle = 0;
	bit long_hold_go = 0;
	bit long_hold_done = 0;
	int hold_left = 0;

	function automatic int eff_w();
		return canvas_w > MAX_W ? MAX_W : int'(canvas_w);
	endfunction

	function automatic int eff_h();
		return canvas_h > MAX_H ? MAX_H : int'(canvas_h);
	endfunction

	function automatic bit drawing_on();
		return eff_w() > 0 && eff_h() > 0;
	endfunction

	function automatic int store_addr(int x, int y);
		int rb;
		rb = (eff_w() + 7) / 8;
		return (y * rb + (x >> 3)) % STORE_SZ;
	endfunction

	function automatic bit on_canvas(int x, int y);
		return drawing_on() && x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
	endfunction

	function automatic void plot(int x, int y, bit wh);
		int a;
		logic [7:0] m;
		if (!on_canvas(x, y))
			return;
		a = store_addr(x, y);
		m = MASK_MSB >> (x & BIT_SEL);
		if (wh)
			mirror_store[a] = mirror_store[a] | m;
		else
			mirror_store[a] = mirror_store[a] & ~m;
	endfunction

	function automatic bit peek(int x, int y);
		logic [7:0] m;
		if (!on_canvas(x, y))
			return 1;
		m = MASK_MSB >> (x & BIT_SEL);
		return (mirror_store[store_addr(x, y)] & m) != 0;
	endfunction

	function automatic void fill_area(int x, int y, int w, int h, bit wh);
		int x0, x1, y0, y1;
		if (!drawing_on() || w <= 0 || h <= 0)
			return;
		x0 = x < 0 ? 0 : x;
		y0 = y < 0 ? 0 : y;
		x1 = x + w > eff_w() ? eff_w() : x + w;
		y1 = y + h > eff_h() ? eff_h() : y + h;
		for (int r = y0; r < y1; r++)
			for (int c = x0; c < x1; c++)
				plot(c, r, wh);
	endfunction

	function automatic void outline_area(int x, int y, int w, int h, bit wh);
		if (!drawing_on() || w <= 0 || h <= 0)
			return;
		fill_area(x, y, w, 1, wh);
		fill_area(x, y + h - 1, w, 1, wh);
		fill_area(x, y, 1, h, wh);
		fill_area(x + w - 1, y, 1, h, wh);
	endfunction

	function automatic void disc_area(int cx, int cy, int rd, bit wh);
		int lo, hi, r2;
		r2 = rd * rd;
		if (!drawing_on() || rd <= 0)
			return;
		for (int dy = -rd; dy <= rd; dy++) begin
			if (cy + dy < 0 || cy + dy >= eff_h())
				continue;
			lo = -rd;
			hi = rd;
			if (cx + lo < 0) lo = -cx;
			if (cx + hi >= eff_w()) hi = eff_w() - 1 - cx;
			for (int dx = lo; dx <= hi; dx++)
				if (dx * dx + dy * dy <= r2)
					plot(cx + dx, cy + dy, wh);
		end
	endfunction

	function automatic void brush_line(int x0, int y0, int x1, int y1, bit wh, int t);
		int dx, dy, sx, sy, err, e2, half, x, y;
		if (!drawing_on())
			return;
		if (t < 1)
			t = 1;
		dx = x1 > x0 ? x1 - x0 : x0 - x1;
		dy = -(y1 > y0 ? y1 - y0 : y0 - y1);
		sx = x0 < x1 ? 1 : -1;
		sy = y0 < y1 ? 1 : -1;
		err = dx + dy;
		half = t / 2;
		x = x0;
		y = y0;
		forever begin
			if (t == 1)
				plot(x, y, wh);
			else
				fill_area(x - half, y - half, t, t, wh);
			if (x == x1 && y == y1)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin err += dy; x += sx; end
			if (e2 <= dx) begin err += dx; y += sy; end
		end
	endfunction

	function automatic bit predict_pixel(draw_cmd_t c);
		int n;
		case (c.kind)
			K_CLEAR: begin
				if (drawing_on()) begin
					n = ((eff_w() + 7) / 8) * eff_h();
					for (int i = 0; i < n; i++)
						mirror_store[i] = c.wht ? BYTE_WHITE : BYTE_BLACK;
				end
			end
			K_PIXEL:   plot(int'(c.xa), int'(c.ya), c.wht);
			K_FILL:    fill_area(int'(c.xa), int'(c.ya), int'(c.sw), int'(c.sh), c.wht);
			K_OUTLINE: outline_area(int'(c.xa), int'(c.ya), int'(c.sw), int'(c.sh), c.wht);
			K_CIRCLE:  disc_area(int'(c.xa), int'(c.ya), int'(c.rad), c.wht);
			K_LINE:    brush_line(int'(c.xa), int'(c.ya), int'(c.xb), int'(c.yb), c.wht,
				int'(c.br));
			K_READ:    return peek(int'(c.xa), int'(c.ya));
			default: ;
		endcase
		return 0;
	endfunction

	// receiver: random bursts of back-pressure plus one long hold
	always @(posedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			long_hold_done <= 1;
			hold_left <= 400;
			out_ready <= 0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (hold_left == 1) begin
			hold_left <= 0;
			out_ready <= 1;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(1, 9);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				errors++;
				$display("unexpected result pixel_white=%0b", pixel_white);
			end else if (pixel_white !== pixel_q[0]) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: pixel_white expected %0b got %0b",
						pixel_q[0], pixel_white);
				void'(pixel_q.pop_front());
			end else begin
				void'(pixel_q.pop_front());
			end
		end
	end

	task automatic send_cmd(draw_cmd_t c, bit has_exp, bit exp_px);
		bit p;
		kind <= c.kind;
		x_a <= c.xa;
		y_a <= c.ya;
		x_b <= c.xb;
		y_b <= c.yb;
		size_w <= c.sw;
		size_h <= c.sh;
		radius <= c.rad;
		white <= c.wht;
		brush <= c.br;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		p = predict_pixel(c);
		pixel_q.push_back(has_exp ? exp_px : p);
		if (c.kind == K_READ)
			reads_checked++;
		cmds_sent++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_WIDTH)
			canvas_w = int'(val);
		else
			canvas_h = int'(val);
	endtask

	function automatic draw_cmd_t mk(logic [2:0] k, int xa, int ya, int xb, int yb,
		int sw, int sh, int rd, bit wh, int br);
		draw_cmd_t c;
		c.kind = k;
		c.xa = 11'(xa);
		c.ya = 11'(ya);
		c.xb = 11'(xb);
		c.yb = 11'(yb);
		c.sw = 11'(sw);
		c.sh = 11'(sh);
		c.rad = 8'(rd);
		c.wht = wh;
		c.br = 4'(br);
		return c;
	endfunction

	function automatic dir_row_t cfg_row(logic idx, int val);
		dir_row_t r;
		r.is_cfg = 1;
		r.cfg_idx = idx;
		r.cfg_val = 9'(val);
		r.c = mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.has_exp = 0;
		r.exp_px = 0;
		return r;
	endfunction

	function automatic dir_row_t cmd_row(draw_cmd_t c, bit has, bit ex);
		dir_row_t r;
		r.is_cfg = 0;
		r.cfg_idx = 0;
		r.cfg_val = 0;
		r.c = c;
		r.has_exp = has;
		r.exp_px = ex;
		return r;
	endfunction

	function automatic logic signed [10:0] pick_coord(int extent, bit allow_full);
		if (allow_full && $urandom_range(0, 19) == 0)
			return 11'($urandom_range(0, 2047));
		return 11'($urandom_range(0, extent + 40) - 20);
	endfunction

	function automatic draw_cmd_t rand_cmd();
		draw_cmd_t c;
		int r;
		bit roomy;
		roomy = eff_w() * eff_h() > 4096;
		r = $urandom_range(0, 99);
		c.kind = r < 3 ? K_CLEAR : r < 15 ? K_PIXEL : r < 27 ? K_FILL :
			r < 37 ? K_OUTLINE : r < 47 ? K_CIRCLE : r < 62 ? K_LINE :
			r < 97 ? K_READ : K_UNUSED;
		if (roomy && c.kind == K_CLEAR && $urandom_range(0, 3) != 0)
			c.kind = K_READ;
		c.xa = pick_coord(eff_w(), !roomy || c.kind == K_READ || c.kind == K_PIXEL);
		c.ya = pick_coord(eff_h(), !roomy || c.kind == K_READ || c.kind == K_PIXEL);
		if (roomy) begin
			c.xb = 11'(c.xa + $urandom_range(0, 32) - 16);
			c.yb = 11'(c.ya + $urandom_range(0, 32) - 16);
			c.sw = 11'($urandom_range(0, 20) - 4);
			c.sh = 11'($urandom_range(0, 20) - 4);
			c.rad = 8'($urandom_range(0, 10));
			c.br = 4'($urandom_range(0, 3));
		end else begin
			c.xb = pick_coord(eff_w(), 1);
			c.yb = pick_coord(eff_h(), 1);
			c.sw = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 2047)) :
				11'($urandom_range(0, eff_w() + 6) - 3);
			c.sh = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 2047)) :
				11'($urandom_range(0, eff_h() + 6) - 3);
			c.rad = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 12));
			c.br = 4'($urandom_range(0, 15));
		end
		c.wht = 1'($urandom_range(0, 1));
		return c;
	endfunction

	initial begin
		dir_row_t dir_tab [$];
		int shapes [9][3] = '{
			'{16, 8, 110}, '{37, 13, 110}, '{1, 1, 60}, '{8, 256, 100},
			'{0, 5, 40}, '{256, 3, 100}, '{100, 60, 180}, '{9, 0, 40},
			'{256, 256, 180}
		};

		for (int i = 0; i < STORE_SZ; i++)
			mirror_store[i] = 0;
		canvas_w = 0;
		canvas_h = 0;

		// disabled engine reads white
		dir_tab.push_back(cmd_row(mk(K_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cfg_row(REG_WIDTH, 16));
		dir_tab.push_back(cmd_row(mk(K_PIXEL, 1, 1, 0, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cfg_row(REG_HEIGHT, 8));
		dir_tab.push_back(cmd_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cmd_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 15, 7, 0, 0, 0, 0, 0, 0, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, -1024, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cmd_row(mk(K_READ, 1023, 1023, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cmd_row(mk(K_PIXEL, 3, 2, 0, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 3, 2, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		dir_tab.push_back(cmd_row(mk(K_FILL, 0, 0, 0, 0, -1024, 5, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_FILL, -3, 1, 0, 0, 10, 3, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_OUTLINE, 2, 2, 0, 0, 1023, 1023, 0, 0, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_OUTLINE, 1, 1, 0, 0, -5, 4, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_CIRCLE, 8, 4, 0, 0, 0, 0, 255, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_CIRCLE, 8, 4, 0, 0, 0, 0, 0, 0, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_LINE, -1024, -1024, 1023, 1023, 0, 0, 0, 0, 15), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_LINE, 0, 7, 15, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 8, 4, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		// oversized registers saturate
		dir_tab.push_back(cfg_row(REG_WIDTH, 511));
		dir_tab.push_back(cfg_row(REG_HEIGHT, 300));
		dir_tab.push_back(cmd_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, 0));
		dir_tab.push_back(cmd_row(mk(K_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0), 1, 1));

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
			else
				send_cmd(dir_tab[i].c, dir_tab[i].has_exp, dir_tab[i].exp_px);
		end

		for (int s = 0; s < 9; s++) begin
			write_reg(REG_WIDTH, 9'(shapes[s][0]));
			write_reg(REG_HEIGHT, 9'(shapes[s][1]));
			settings_done++;
			send_cmd(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'($urandom_range(0, 1)), 0), 0, 0);
			for (int n = 0; n < shapes[s][2]; n++) begin
				if (s == 1 && n == 20)
					long_hold_go <= 1;
				if (s == 6 && n == 60)
					drain();
				if (cmds_sent > 860)
					no_idle = 1;
				send_cmd(rand_cmd(), 0, 0);
			end
		end

		in_valid <= 0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		errors += pixel_q.size();
		$display("Ran %0d draw commands over %0d canvas sizes", cmds_sent, settings_done);
		$display("Checked %0d pixel reads, %0d mismatches", reads_checked, mismatches);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
